### hdl/script_token_lexer_defines.svh
// assertion macros for the script token lexer checker
`ifndef SCRIPT_TOKEN_LEXER_DEFINES_SVH
`define SCRIPT_TOKEN_LEXER_DEFINES_SVH

// same-cycle implication, checked on every clock once out of reset
`define STL_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lexer check failed");

// next-cycle implication
`define STL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lexer check failed");

`endif

### hdl/stl_pkg.sv
// types, character codes and classifiers shared by the lexer modules
package stl_pkg;

  typedef enum logic [2:0] {
    MODE_SKIP    = 3'd0,
    MODE_SLASH   = 3'd1,
    MODE_COMMENT = 3'd2,
    MODE_QUOTE   = 3'd3,
    MODE_WORD    = 3'd4
  } mode_t;

  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_NEWLINE = 8'h0a;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_DQUOTE  = 8'h22;
  localparam logic [7:0] CH_SQUOTE  = 8'h27;
  localparam logic [7:0] CH_LPAREN  = 8'h28;
  localparam logic [7:0] CH_RPAREN  = 8'h29;
  localparam logic [7:0] CH_SLASH   = 8'h2f;
  localparam logic [7:0] CH_COLON   = 8'h3a;
  localparam logic [7:0] CH_LBRACE  = 8'h7b;
  localparam logic [7:0] CH_RBRACE  = 8'h7d;

  typedef struct packed {
    logic       has_byte;
    logic [7:0] token_byte;
    logic       last;
    logic       quoted;
    logic       done_res;
  } res_t;

  // up to two result items produced by one input item
  typedef struct packed {
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } push_t;

  function automatic logic is_single(input logic [7:0] b);
    return (b == CH_LBRACE) || (b == CH_RBRACE) || (b == CH_RPAREN) ||
           (b == CH_LPAREN) || (b == CH_SQUOTE) || (b == CH_COLON);
  endfunction

  function automatic logic is_word_byte(input logic [7:0] b);
    return (b > CH_SPACE) && !b[7] && !is_single(b);
  endfunction

  function automatic res_t mk_res(input logic has, input logic [7:0] b,
                                  input logic lst, input logic q, input logic dn);
    res_t r;
    r.has_byte   = has;
    r.token_byte = b;
    r.last       = lst;
    r.quoted     = q;
    r.done_res   = dn;
    return r;
  endfunction

endpackage

### hdl/stl_front.sv
// front end: takes source bytes, tracks lexer mode, forms result items
module stl_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [7:0]        char_in,
  output stl_pkg::push_t    push
);

  stl_pkg::mode_t mode;
  stl_pkg::mode_t mode_next;
  stl_pkg::push_t dec;
  logic           is_nul;

  assign is_nul = (char_in == stl_pkg::CH_NUL);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= stl_pkg::MODE_SKIP;
    end else if (accept) begin
      mode <= mode_next;
    end
  end

  always_comb begin
    mode_next = mode;
    dec       = '0;
    unique case (mode)
      stl_pkg::MODE_SLASH: begin
        if (char_in == stl_pkg::CH_SLASH) begin
          mode_next = stl_pkg::MODE_COMMENT;
        end else if (stl_pkg::is_word_byte(char_in)) begin
          dec.n     = 2'd2;
          dec.r0    = stl_pkg::mk_res(1'b1, stl_pkg::CH_SLASH, 1'b0, 1'b0, 1'b0);
          dec.r1    = stl_pkg::mk_res(1'b1, char_in, 1'b0, 1'b0, 1'b0);
          mode_next = stl_pkg::MODE_WORD;
        end else if (stl_pkg::is_single(char_in)) begin
          dec.n     = 2'd2;
          dec.r0    = stl_pkg::mk_res(1'b1, stl_pkg::CH_SLASH, 1'b1, 1'b0, 1'b0);
          dec.r1    = stl_pkg::mk_res(1'b1, char_in, 1'b1, 1'b0, 1'b0);
          mode_next = stl_pkg::MODE_SKIP;
        end else begin
          dec.n     = 2'd1;
          dec.r0    = stl_pkg::mk_res(1'b1, stl_pkg::CH_SLASH, 1'b1, 1'b0, is_nul);
          mode_next = stl_pkg::MODE_SKIP;
        end
      end
      stl_pkg::MODE_COMMENT: begin
        if (is_nul) begin
          dec.n     = 2'd1;
          dec.r0    = stl_pkg::mk_res(1'b0, 8'h00, 1'b0, 1'b0, 1'b1);
          mode_next = stl_pkg::MODE_SKIP;
        end else if (char_in == stl_pkg::CH_NEWLINE) begin
          mode_next = stl_pkg::MODE_SKIP;
        end
      end
      stl_pkg::MODE_QUOTE: begin
        dec.n = 2'd1;
        if (char_in == stl_pkg::CH_DQUOTE || is_nul) begin
          dec.r0    = stl_pkg::mk_res(1'b0, 8'h00, 1'b1, 1'b1, is_nul);
          mode_next = stl_pkg::MODE_SKIP;
        end else begin
          dec.r0 = stl_pkg::mk_res(1'b1, char_in, 1'b0, 1'b1, 1'b0);
        end
      end
      stl_pkg::MODE_WORD: begin
        if (stl_pkg::is_word_byte(char_in)) begin
          dec.n  = 2'd1;
          dec.r0 = stl_pkg::mk_res(1'b1, char_in, 1'b0, 1'b0, 1'b0);
        end else if (stl_pkg::is_single(char_in)) begin
          dec.n     = 2'd2;
          dec.r0    = stl_pkg::mk_res(1'b0, 8'h00, 1'b1, 1'b0, 1'b0);
          dec.r1    = stl_pkg::mk_res(1'b1, char_in, 1'b1, 1'b0, 1'b0);
          mode_next = stl_pkg::MODE_SKIP;
        end else begin
          dec.n     = 2'd1;
          dec.r0    = stl_pkg::mk_res(1'b0, 8'h00, 1'b1, 1'b0, is_nul);
          mode_next = stl_pkg::MODE_SKIP;
        end
      end
      default: begin
        // skipping whitespace; unused codes behave the same
        mode_next = stl_pkg::MODE_SKIP;
        if (is_nul) begin
          dec.n  = 2'd1;
          dec.r0 = stl_pkg::mk_res(1'b0, 8'h00, 1'b0, 1'b0, 1'b1);
        end else if (char_in == stl_pkg::CH_SLASH) begin
          mode_next = stl_pkg::MODE_SLASH;
        end else if (char_in == stl_pkg::CH_DQUOTE) begin
          mode_next = stl_pkg::MODE_QUOTE;
        end else if (stl_pkg::is_single(char_in)) begin
          dec.n  = 2'd1;
          dec.r0 = stl_pkg::mk_res(1'b1, char_in, 1'b1, 1'b0, 1'b0);
        end else if (stl_pkg::is_word_byte(char_in)) begin
          dec.n     = 2'd1;
          dec.r0    = stl_pkg::mk_res(1'b1, char_in, 1'b0, 1'b0, 1'b0);
          mode_next = stl_pkg::MODE_WORD;
        end
      end
    endcase
  end

  always_comb begin
    push = dec;
    if (!accept) begin
      push.n = 2'd0;
    end
  end

endmodule

### hdl/stl_queue.sv
// back end: result queue taking up to two items a cycle, draining one while out_ready is high
module stl_queue #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  stl_pkg::push_t push,
  output logic           space,
  output logic           out_valid,
  input  logic           out_ready,
  output stl_pkg::res_t  head
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  stl_pkg::res_t mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic [PW-1:0] wr_ptr_p1;
  logic          pop;

  assign wr_ptr_p1 = wr_ptr + PW'(1);
  assign pop       = out_valid && out_ready;
  assign out_valid = (count != '0);
  assign head      = mem[rd_ptr];
  // room for the worst case of one input item
  assign space     = (count <= CW'(DEPTH - 2));

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      mem[wr_ptr] <= push.r0;
    end
    if (push.n == 2'd2) begin
      mem[wr_ptr_p1] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PW'(push.n);
      if (pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      count <= count + CW'(push.n) - CW'(pop);
    end
  end

endmodule

### hdl/script_token_lexer.sv
// top level of the streaming script token lexer
// result items are formed combinationally in the front end and registered in the queue
// throughput: one input item per cycle; in_ready drops only when the queue cannot take
//   the two items a byte may produce; output drains one per cycle when out_ready is high
// reset: synchronous rst returns the lexer to skipping whitespace and empties the queue
module script_token_lexer #(
  parameter int QDEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] char_in,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       has_byte,
  output logic [7:0] token_byte,
  output logic       last,
  output logic       quoted,
  output logic       done_res
);

  stl_pkg::push_t push;
  stl_pkg::res_t  head;
  logic           accept;

  assign accept = in_valid && in_ready;

  stl_front u_front (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .char_in (char_in),
    .push    (push)
  );

  stl_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .space     (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head)
  );

  assign has_byte   = head.has_byte;
  assign token_byte = head.token_byte;
  assign last       = head.last;
  assign quoted     = head.quoted;
  assign done_res   = head.done_res;

endmodule

### hdl/stl_checker.sv
// port-level checks for the script token lexer, bound to the top level
`include "script_token_lexer_defines.svh"

module stl_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic       has_byte,
  input logic [7:0] token_byte,
  input logic       last,
  input logic       quoted,
  input logic       done_res
);

  // a stalled output item stays offered
  `STL_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(token_byte))
  // an item without a character carries a zero byte
  `STL_ASSERT_NOW(a_empty_zero, out_valid && !has_byte, token_byte == 8'h00)
  // an item with neither a character nor an end mark only reports end of data
  `STL_ASSERT_NOW(a_bare_done, out_valid && !has_byte && !last, done_res)
  // quoted characters never close their token; the closing quote brings the end mark
  `STL_ASSERT_NOW(a_quote_open, out_valid && quoted && has_byte, !last && !done_res)

endmodule

bind script_token_lexer stl_checker u_stl_checker (.*);
